@@ src/crpc_pkg.sv @@
// ----------------------------------------------------------------------------
// crpc_pkg
// shared types, constants and the crc-15 pec table function for the cell
// register frame checker
// ----------------------------------------------------------------------------
package crpc_pkg;

	localparam int unsigned MAX_DEVICES      = 16;
	localparam int unsigned FRAME_DATA_BYTES = 6;

	localparam logic [15:0] PEC_SEED        = 16'd16;
	localparam logic [15:0] PEC_POLY        = 16'h4599;
	localparam logic [3:0]  CELLS_PER_GROUP = 4'd3;
	localparam logic [4:0]  ERR_LIMIT       = 5'd16;
	localparam logic [4:0]  DEV_COUNT_MIN   = 5'd1;
	localparam logic [4:0]  DEV_COUNT_MAX   = 5'(MAX_DEVICES);

	localparam logic [2:0] POS_PEC_HIGH = 3'(FRAME_DATA_BYTES);
	localparam logic [2:0] POS_PEC_LOW  = 3'(FRAME_DATA_BYTES + 1);

	typedef enum logic {
		KIND_CELL  = 1'b0,
		KIND_CHECK = 1'b1
	} result_kind_t;

	typedef struct packed {
		logic [1:0] register_group;
		logic       first_byte;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		result_kind_t result_kind;
		logic         last;
		logic [4:0]   error_count;
		logic         pec_match;
		logic [15:0]  cell_code;
		logic [3:0]   cell_index;
		logic [3:0]   device_index;
	} result_t;

	function automatic logic [15:0] pec_table_entry(input logic [7:0] addr);
		logic [15:0] r;
		r = {1'b0, addr, 7'b0};
		for (int b = 0; b < 8; b++) begin
			if (r[14]) begin
				r = (r << 1) ^ PEC_POLY;
			end else begin
				r = r << 1;
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] pec_feed(input logic [15:0] crc, input logic [7:0] data);
		logic [7:0] addr;
		addr = crc[14:7] ^ data;
		return {crc[7:0], 8'h00} ^ pec_table_entry(addr);
	endfunction

endpackage

@@ src/crpc_in_stage.sv @@
// ----------------------------------------------------------------------------
// crpc_in_stage
// input register: holds one received beat until the frame stage takes it
// ----------------------------------------------------------------------------
module crpc_in_stage
	import crpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  in_item_t  s_item,
	input  logic      take,
	output logic      item_valid,
	output in_item_t  item
);

	logic     valid_s1;
	in_item_t item_s1;

	assign s_tready   = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_item;
		end
	end

endmodule

@@ src/crpc_frame.sv @@
// ----------------------------------------------------------------------------
// crpc_frame
// frame parser, pec check and result register
// ----------------------------------------------------------------------------
module crpc_frame
	import crpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wen,
	input  logic [4:0] cfg_wdata,
	input  logic      item_valid,
	input  in_item_t  item,
	output logic      take,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   out_data
);

	logic [2:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  low_q;
	logic [7:0]  pec_hi_q;
	logic [3:0]  dev_q;
	logic [1:0]  group_q;
	logic [4:0]  mism_q;
	logic [4:0]  dev_count_q;
	logic        out_valid_q;
	result_t     out_q;

	logic [2:0]  pos_e;
	logic [15:0] crc_e;
	logic [3:0]  dev_e;
	logic [1:0]  group_e;
	logic [4:0]  mism_e;
	logic [2:0]  pos_n;
	logic [15:0] crc_n;
	logic [3:0]  dev_n;
	logic [4:0]  mism_n;
	logic [4:0]  eff_count;
	logic [15:0] received;
	logic        match;
	logic        has_result;
	result_t     res;

	assign take      = item_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		pos_e   = item.first_byte ? 3'd0 : pos_q;
		crc_e   = item.first_byte ? PEC_SEED : crc_q;
		dev_e   = item.first_byte ? 4'd0 : dev_q;
		mism_e  = item.first_byte ? 5'd0 : mism_q;
		group_e = item.first_byte ? item.register_group : group_q;

		if (dev_count_q < DEV_COUNT_MIN) begin
			eff_count = DEV_COUNT_MIN;
		end else if (dev_count_q > DEV_COUNT_MAX) begin
			eff_count = DEV_COUNT_MAX;
		end else begin
			eff_count = dev_count_q;
		end

		received = {pec_hi_q, item.rx_byte};
		match    = (received == {crc_e[14:0], 1'b0});

		pos_n      = pos_e;
		crc_n      = crc_e;
		dev_n      = dev_e;
		mism_n     = mism_e;
		has_result = 1'b0;
		res        = '0;
		res.device_index = dev_e;

		if (pos_e < POS_PEC_HIGH) begin
			crc_n = pec_feed(crc_e, item.rx_byte);
			pos_n = pos_e + 3'd1;
			if (pos_e[0]) begin
				has_result      = 1'b1;
				res.result_kind = KIND_CELL;
				res.cell_index  = ({2'b00, group_e} * CELLS_PER_GROUP) + {2'b00, pos_e[2:1]};
				res.cell_code   = {item.rx_byte, low_q};
			end
		end else if (pos_e == POS_PEC_HIGH) begin
			pos_n = POS_PEC_LOW;
		end else begin
			if (!match && mism_e < ERR_LIMIT) begin
				mism_n = mism_e + 5'd1;
			end
			has_result      = 1'b1;
			res.result_kind = KIND_CHECK;
			res.pec_match   = match;
			res.error_count = mism_n;
			res.last        = ({1'b0, dev_e} == (eff_count - 5'd1));
			dev_n           = dev_e + 4'd1;
			pos_n           = 3'd0;
			crc_n           = PEC_SEED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 3'd0;
			crc_q       <= PEC_SEED;
			low_q       <= 8'd0;
			pec_hi_q    <= 8'd0;
			dev_q       <= 4'd0;
			group_q     <= 2'd0;
			mism_q      <= 5'd0;
			dev_count_q <= DEV_COUNT_MIN;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				dev_count_q <= cfg_wdata;
			end
			if (take) begin
				pos_q   <= pos_n;
				crc_q   <= crc_n;
				dev_q   <= dev_n;
				group_q <= group_e;
				mism_q  <= mism_n;
				if (pos_e < POS_PEC_HIGH && !pos_e[0]) begin
					low_q <= item.rx_byte;
				end
				if (pos_e == POS_PEC_HIGH) begin
					pec_hi_q <= item.rx_byte;
				end
			end
			if (take && has_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_result) begin
			out_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_mism_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mism_q <= ERR_LIMIT)
		else $error("mismatch count above limit");

	a_pec_high_then_low: assert property (@(posedge clk) disable iff (!arst_n)
		take && !item.first_byte && pos_q == POS_PEC_HIGH |=> pos_q == POS_PEC_LOW)
		else $error("pec low byte position not reached");

	a_cell_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.result_kind == KIND_CELL |-> out_q.cell_index <= 4'd11)
		else $error("cell index out of range");

	a_check_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.result_kind == KIND_CHECK |->
			out_q.cell_code == 16'd0 && out_q.cell_index == 4'd0)
		else $error("check result carries cell data");

	a_cell_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.result_kind == KIND_CELL |->
			!out_q.last && !out_q.pec_match && out_q.error_count == 5'd0)
		else $error("cell result carries check data");
`endif

endmodule

@@ src/cell_register_frame_pec_checker.sv @@
// ----------------------------------------------------------------------------
// cell_register_frame_pec_checker
// parses cell register readback frames, emits cell codes and pec checks
// ----------------------------------------------------------------------------
// path: an accepted input beat is held in the input register, and its result, if any, in the result register
// throughput: one input beat per cycle while m_tready does not stall results, set by the
// single input register and the single result register
// reset: arst_n clears frame position, counters and valid flags at once,
// crc seed is 16 and the device count register returns to 1
// ----------------------------------------------------------------------------
module cell_register_frame_pec_checker
	import crpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [4:0]  cfg_wdata,  // device_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // rx_byte
	input  logic [2:0]  s_tuser,    // first_byte, register_group
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // device_index, cell_index, cell_code, pec_match,
	                                // error_count, zero pad
	output logic        m_tuser,    // result_kind
	output logic        m_tlast     // last
);

	in_item_t s_item;
	in_item_t item;
	logic     item_valid;
	logic     take;
	result_t  out_data;

	assign s_item.rx_byte        = s_tdata;
	assign s_item.first_byte     = s_tuser[0];
	assign s_item.register_group = s_tuser[2:1];

	crpc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_item     (s_item),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	crpc_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item       (item),
		.take       (take),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_data)
	);

	assign m_tdata = {2'b00, out_data.error_count, out_data.pec_match, out_data.cell_code,
	                  out_data.cell_index, out_data.device_index};
	assign m_tuser = out_data.result_kind;
	assign m_tlast = out_data.last;

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// testbench for cell_register_frame_pec_checker: streams readback bytes
// built as whole device frames with good or corrupted crc-15 pecs, plus
// broken frames, over-long reads and noise, and predicts every cell code
// and frame check beat for comparison against the result stream under
// random gaps and stalls
// ----------------------------------------------------------------------------
module tb_top
	import crpc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned PHASE_BYTES    = 132;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic [2:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	cell_register_frame_pec_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	in_item_t    byte_queue[$];
	result_t     expected_results[$];
	int unsigned fail_count   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_gap     = 0;
	int unsigned ready_stall  = 0;
	bit          no_idle      = 1'b0;

	// predicted block state
	logic [2:0]  frame_pos;
	logic [14:0] pec_rem;
	logic [7:0]  low_byte;
	logic [7:0]  pec_high;
	logic [3:0]  dev_ctr;
	logic [1:0]  read_group;
	logic [4:0]  err_ctr;
	logic [4:0]  dev_count_reg;

	// bitwise crc-15, msb first, implicit x^15 term
	function automatic logic [14:0] crc15_step(input logic [14:0] rem, input logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = d[i] ^ rem[14];
			rem = {rem[13:0], 1'b0};
			if (fb) begin
				rem = rem ^ PEC_POLY[14:0];
			end
		end
		return rem;
	endfunction

	function automatic logic [4:0] effective_devices(input logic [4:0] count);
		if (count == 5'd0) begin
			return DEV_COUNT_MIN;
		end
		return (count > DEV_COUNT_MAX) ? DEV_COUNT_MAX : count;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 8'h00;
		end else if (r == 1) begin
			return 8'hff;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic predict_byte(input logic [7:0] b, input logic first, input logic [1:0] grp);
		result_t     r;
		logic [2:0]  pos;
		logic [15:0] computed;
		logic        match;
		r = '0;
		if (first) begin
			frame_pos  = '0;
			pec_rem    = PEC_SEED[14:0];
			dev_ctr    = '0;
			err_ctr    = '0;
			read_group = grp;
		end
		if (frame_pos < POS_PEC_HIGH) begin
			pos       = frame_pos;
			pec_rem   = crc15_step(pec_rem, b);
			frame_pos = pos + 3'd1;
			if (!pos[0]) begin
				low_byte = b;
			end else begin
				r.result_kind  = KIND_CELL;
				r.device_index = dev_ctr;
				r.cell_index   = {2'b00, read_group} * CELLS_PER_GROUP + {2'b00, pos[2:1]};
				r.cell_code    = {b, low_byte};
				expected_results.push_back(r);
			end
		end else if (frame_pos == POS_PEC_HIGH) begin
			pec_high  = b;
			frame_pos = POS_PEC_LOW;
		end else begin
			computed = {pec_rem, 1'b0};
			match    = ({pec_high, b} == computed);
			if (!match && err_ctr < ERR_LIMIT) begin
				err_ctr = err_ctr + 5'd1;
			end
			r.result_kind  = KIND_CHECK;
			r.device_index = dev_ctr;
			r.pec_match    = match;
			r.error_count  = err_ctr;
			r.last         = ({1'b0, dev_ctr} == effective_devices(dev_count_reg) - 5'd1);
			expected_results.push_back(r);
			dev_ctr   = dev_ctr + 4'd1;
			frame_pos = '0;
			pec_rem   = PEC_SEED[14:0];
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic first, input logic [1:0] grp);
		in_item_t it;
		it.rx_byte        = b;
		it.first_byte     = first;
		it.register_group = grp;
		byte_queue.push_back(it);
	endtask

	task automatic push_frame(input logic first, input logic [1:0] grp, input logic [47:0] data,
	                          input bit bad_pec);
		logic [14:0] rem;
		logic [15:0] pec;
		rem = PEC_SEED[14:0];
		for (int k = 0; k < 6; k++) begin
			rem = crc15_step(rem, data[8*k +: 8]);
		end
		pec = {rem, 1'b0};
		if (bad_pec) begin
			pec = pec ^ 16'($urandom_range(1, 65535));
		end
		for (int k = 0; k < 6; k++) begin
			push_byte(data[8*k +: 8], first && k == 0, (k == 0) ? grp : 2'($urandom_range(0, 3)));
		end
		push_byte(pec[15:8], 1'b0, 2'($urandom_range(0, 3)));
		push_byte(pec[7:0], 1'b0, 2'($urandom_range(0, 3)));
	endtask

	function automatic logic [47:0] rand_frame_data();
		logic [47:0] d;
		for (int k = 0; k < 6; k++) begin
			d[8*k +: 8] = rand_byte();
		end
		return d;
	endfunction

	task automatic push_read(input logic [4:0] count);
		int unsigned mode;
		int unsigned n;
		int unsigned err_pct;
		int unsigned tail;
		logic [1:0]  grp;
		logic [4:0]  eff;
		eff     = effective_devices(count);
		mode    = $urandom_range(0, 99);
		grp     = 2'($urandom_range(0, 3));
		n       = eff;
		err_pct = 15;
		tail    = 0;
		if (mode >= 90) begin
			// noise: loose bytes, start flag at random
			n = 0;
			repeat ($urandom_range(1, 10)) begin
				push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
				          2'($urandom_range(0, 3)));
			end
		end else if (mode >= 80) begin
			// read cut short, then a partial frame
			n    = $urandom_range(0, eff - 1);
			tail = $urandom_range(1, 7);
		end else if (mode >= 70) begin
			// frames past the final device
			n       = eff + $urandom_range(1, 20);
			err_pct = $urandom_range(0, 1) ? 90 : 30;
		end
		for (int unsigned i = 0; i < n; i++) begin
			push_frame(i == 0, grp, rand_frame_data(), $urandom_range(0, 99) < err_pct);
		end
		for (int unsigned i = 0; i < tail; i++) begin
			push_byte(rand_byte(), n == 0 && i == 0, grp);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (byte_queue.size() != 0 || s_tvalid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_device_count(input logic [4:0] value);
		wait_idle();
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		dev_count_reg = value;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin : byte_driver
		in_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata, s_tuser[0], s_tuser[2:1]);
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (byte_queue.size() != 0) begin
					it = byte_queue.pop_front();
					s_tdata  <= it.rx_byte;
					s_tuser  <= {it.register_group, it.first_byte};
					s_tvalid <= 1'b1;
					send_gap <= pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_t want;
		if (!arst_n) begin
			m_tready    <= 1'b0;
			ready_stall <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual 0x%0h", $time, m_tdata);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", want.result_kind, m_tuser);
					check_field("device_index", want.device_index, m_tdata[3:0]);
					check_field("cell_index", want.cell_index, m_tdata[7:4]);
					check_field("cell_code", want.cell_code, m_tdata[23:8]);
					check_field("pec_match", want.pec_match, m_tdata[24]);
					check_field("error_count", want.error_count, m_tdata[29:25]);
					check_field("pad", 0, m_tdata[31:30]);
					check_field("last", want.last, m_tlast);
				end
			end
			if (ready_stall > 0) begin
				ready_stall <= ready_stall - 1;
				m_tready    <= 1'b0;
			end else begin
				ready_stall <= pick_gap();
				m_tready    <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_wen || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [4:0] settings[$];
		int unsigned start_size;
		frame_pos     = '0;
		pec_rem       = PEC_SEED[14:0];
		low_byte      = '0;
		pec_high      = '0;
		dev_ctr       = '0;
		read_group    = '0;
		err_ctr       = '0;
		dev_count_reg = DEV_COUNT_MIN;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: two-device read, extremes of data and group, bad pec on the final device
		write_device_count(5'd2);
		push_frame(1'b1, 2'd3, 48'hffff_ffff_ffff, 1'b0);
		push_frame(1'b0, 2'd2, 48'h0000_0000_0000, 1'b1);
		// new read starting in the middle of a frame
		push_byte(8'h5a, 1'b1, 2'd1);
		push_byte(8'ha5, 1'b0, 2'd2);
		push_byte(8'h80, 1'b0, 2'd0);
		push_frame(1'b1, 2'd0, 48'h0102_0304_8001, 1'b0);

		settings = '{5'd1, 5'd0, 5'd16, 5'd31, 5'(17 + $urandom_range(0, 13)),
		             5'(2 + $urandom_range(0, 13)), 5'd5};
		foreach (settings[i]) begin
			write_device_count(settings[i]);
			no_idle = ($urandom_range(0, 3) == 0);
			start_size = byte_queue.size();
			while (byte_queue.size() - start_size < PHASE_BYTES) begin
				push_read(settings[i]);
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/crpc_pkg.sv
src/crpc_in_stage.sv
src/crpc_frame.sv
src/cell_register_frame_pec_checker.sv
sim/tb_top.sv
